/* rtl/sle_pkg.sv */
// sorted list engine: shared item types, codes and handshake structs
// no dependencies; used by every module of the block
package sle_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 7;
    localparam int COUNT_W = 7;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [RANK_W-1:0]  rank;
        logic [COUNT_W-1:0] count;
        logic [1:0]         status;
    } t_out_item;

    // scan token flags rippling down the cell chain
    typedef struct packed {
        logic valid;
        logic eq_seen;
        logic stop_seen;
    } t_scan;

    // one-cycle commit command broadcast to all cells
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

endpackage

/* rtl/sorted_list_engine.sv */
// an item's scan token passes the launch register and the token register of each
// cell, one cell per cycle; commit then fills the result register once free, and
// a new item is taken only after the previous one has committed
// reset: synchronous active-low i_rst_n empties the list at once, clears the
// order bit to ascending; no clearing pass
module sorted_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sle_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sle_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int IW = $clog2(CAPACITY);

    logic                               r_descending;
    logic signed [sle_pkg::VALUE_W-1:0] w_key;
    sle_pkg::t_cmd                      w_cmd;
    logic [IW-1:0]                      w_cmd_pos;
    sle_pkg::t_scan                     w_tok      [0:CAPACITY];
    logic [IW-1:0]                      w_eq_pos   [0:CAPACITY];
    logic [IW-1:0]                      w_stop_pos [0:CAPACITY];
    logic [CAPACITY:0]                  w_tok_vld;
    // shift neighbors: cell i sits at entry i + 1, both ends tied off
    logic signed [sle_pkg::VALUE_W-1:0] w_val_chain [0:CAPACITY+1];
    logic [CAPACITY+1:0]                w_vld_chain;
    logic [CAPACITY-1:0]                w_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
        end else if (i_cfg_valid) begin
            r_descending <= i_cfg_data;
        end
    end

    sle_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_key       (w_key),
        .o_tok       (w_tok[0]),
        .i_tok_last  (w_tok[CAPACITY]),
        .i_eq_pos    (w_eq_pos[CAPACITY]),
        .i_stop_pos  (w_stop_pos[CAPACITY]),
        .o_cmd       (w_cmd),
        .o_cmd_pos   (w_cmd_pos)
    );

    assign w_eq_pos[0]             = '0;
    assign w_stop_pos[0]           = '0;
    assign w_val_chain[0]          = '0;
    assign w_val_chain[CAPACITY+1] = '0;
    assign w_vld_chain[0]          = 1'b0;
    assign w_vld_chain[CAPACITY+1] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sle_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_key        (w_key),
            .i_descending (r_descending),
            .i_tok        (w_tok[i]),
            .i_eq_pos     (w_eq_pos[i]),
            .i_stop_pos   (w_stop_pos[i]),
            .i_cmd        (w_cmd),
            .i_cmd_pos    (w_cmd_pos),
            .i_prev_value (w_val_chain[i]),
            .i_prev_valid (w_vld_chain[i]),
            .i_next_value (w_val_chain[i+2]),
            .i_next_valid (w_vld_chain[i+2]),
            .o_tok        (w_tok[i+1]),
            .o_eq_pos     (w_eq_pos[i+1]),
            .o_stop_pos   (w_stop_pos[i+1]),
            .o_value      (w_val_chain[i+1]),
            .o_valid      (w_vld_chain[i+1])
        );
    end

    for (genvar j = 0; j <= CAPACITY; j++) begin : g_tok_vld
        assign w_tok_vld[j] = w_tok[j].valid;
    end

    assign w_valid = w_vld_chain[CAPACITY:1];

`ifndef SYNTH
    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[CAPACITY-1:1] & ~w_valid[CAPACITY-2:0]) == '0)
        else $error("occupied cells are not a prefix");

    // only one scan token travels the chain at a time
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one scan token in flight");

    // the list is only reshaped once the scan has drained
    a_commit_idle_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.ins || w_cmd.rem) |-> (w_tok_vld == '0))
        else $error("commit while a scan token is in flight");

    // a new item is only taken with the chain quiet and no commit pending
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (w_tok_vld == '0) && !w_cmd.ins && !w_cmd.rem)
        else $error("item accepted during a scan or commit");
`endif

endmodule

/* rtl/sle_cell.sv */
// sorted list engine: one storage cell of the chain, holds the entry at its rank
// depends on sle_pkg; neighbors feed the token and shift data
module sle_cell #(
    parameter int CAPACITY = 64,
    parameter int INDEX    = 0,
    localparam int IW      = $clog2(CAPACITY)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [sle_pkg::VALUE_W-1:0] i_key,
    input  logic                              i_descending,
    input  sle_pkg::t_scan                    i_tok,
    input  logic [IW-1:0]                     i_eq_pos,
    input  logic [IW-1:0]                     i_stop_pos,
    input  sle_pkg::t_cmd                     i_cmd,
    input  logic [IW-1:0]                     i_cmd_pos,
    input  logic signed [sle_pkg::VALUE_W-1:0] i_prev_value,
    input  logic                              i_prev_valid,
    input  logic signed [sle_pkg::VALUE_W-1:0] i_next_value,
    input  logic                              i_next_valid,
    output sle_pkg::t_scan                    o_tok,
    output logic [IW-1:0]                     o_eq_pos,
    output logic [IW-1:0]                     o_stop_pos,
    output logic signed [sle_pkg::VALUE_W-1:0] o_value,
    output logic                              o_valid
);

    localparam logic [IW-1:0] IDX = IW'(INDEX);

    logic signed [sle_pkg::VALUE_W-1:0] r_value, n_value;
    logic                               r_valid, n_valid;
    sle_pkg::t_scan                     r_tok, n_tok;
    logic [IW-1:0]                      r_eq_pos, n_eq_pos;
    logic [IW-1:0]                      r_stop_pos, n_stop_pos;
    logic                               ahead;
    logic                               hit;
    logic                               stop_here;

    // stored value stays ahead of the key in the current order
    assign ahead     = i_descending ? (r_value >= i_key) : (r_value <= i_key);
    assign hit       = r_valid && (r_value == i_key);
    assign stop_here = !r_valid || !ahead;

    always_comb begin
        n_tok.valid     = i_tok.valid;
        n_tok.eq_seen   = i_tok.eq_seen | hit;
        n_tok.stop_seen = i_tok.stop_seen | stop_here;
        n_eq_pos        = i_tok.eq_seen ? i_eq_pos : IDX;
        n_stop_pos      = i_tok.stop_seen ? i_stop_pos : IDX;
    end

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            if (IDX > i_cmd_pos) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end else if (IDX == i_cmd_pos) begin
                n_value = i_key;
                n_valid = 1'b1;
            end
        end else if (i_cmd.rem) begin
            if (IDX >= i_cmd_pos) begin
                n_value = i_next_value;
                n_valid = i_next_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_valid   <= n_valid;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_eq_pos   <= n_eq_pos;
        r_stop_pos <= n_stop_pos;
    end

    assign o_tok      = r_tok;
    assign o_eq_pos   = r_eq_pos;
    assign o_stop_pos = r_stop_pos;
    assign o_value    = r_value;
    assign o_valid    = r_valid;

endmodule

/* rtl/sle_ctrl.sv */
// sorted list engine: request sequencer, entry count and result register
// depends on sle_pkg; drives the scan token and commit command of the chain
module sle_ctrl #(
    parameter int CAPACITY = 64,
    localparam int IW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sle_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sle_pkg::t_out_item                 o_out_data,
    output logic signed [sle_pkg::VALUE_W-1:0] o_key,
    output sle_pkg::t_scan                     o_tok,
    input  sle_pkg::t_scan                     i_tok_last,
    input  logic [IW-1:0]                      i_eq_pos,
    input  logic [IW-1:0]                      i_stop_pos,
    output sle_pkg::t_cmd                      o_cmd,
    output logic [IW-1:0]                      o_cmd_pos
);

    sle_pkg::t_state                    r_state, n_state;
    logic [1:0]                         r_action;
    logic signed [sle_pkg::VALUE_W-1:0] r_key;
    logic                               r_launch;
    logic                               r_found;
    logic [IW-1:0]                      r_eq_pos;
    logic [IW-1:0]                      r_stop_pos;
    logic [CW-1:0]                      r_count, n_count;
    logic                               r_out_valid;
    sle_pkg::t_out_item                 r_out_data, n_out_data;
    logic                               accept;
    logic                               out_free;
    logic                               commit;
    logic                               full;
    logic [IW-1:0]                      rank;

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (r_count == CW'(CAPACITY));
    assign accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sle_pkg::S_IDLE:   if (i_in_valid) n_state = sle_pkg::S_SCAN;
            sle_pkg::S_SCAN:   if (i_tok_last.valid) n_state = sle_pkg::S_COMMIT;
            sle_pkg::S_COMMIT: if (out_free) n_state = sle_pkg::S_IDLE;
            default:           n_state = sle_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            sle_pkg::S_IDLE:   o_in_ready = 1'b1;
            sle_pkg::S_SCAN:   o_in_ready = 1'b0;
            sle_pkg::S_COMMIT: commit = out_free;
            default:           o_in_ready = 1'b0;
        endcase
    end

    // result and list update from the scan outcome
    always_comb begin
        o_cmd      = '0;
        o_cmd_pos  = r_stop_pos;
        n_count    = r_count;
        rank       = '0;
        n_out_data.status = sle_pkg::ST_DONE;
        unique case (r_action)
            sle_pkg::ACT_INSERT: begin
                if (full) begin
                    n_out_data.status = sle_pkg::ST_FULL;
                end else begin
                    o_cmd.ins = commit;
                    o_cmd_pos = r_stop_pos;
                    rank      = r_stop_pos;
                    n_count   = r_count + CW'(1);
                end
            end
            sle_pkg::ACT_REMOVE: begin
                if (r_found) begin
                    o_cmd.rem = commit;
                    o_cmd_pos = r_eq_pos;
                    rank      = r_eq_pos;
                    n_count   = r_count - CW'(1);
                end else begin
                    n_out_data.status = sle_pkg::ST_MISS;
                end
            end
            default: begin
                // find, and the unused code handled the same way
                if (r_found) rank = r_eq_pos;
            end
        endcase
        n_out_data.found = r_found;
        n_out_data.rank  = sle_pkg::RANK_W'(rank);
        n_out_data.count = sle_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sle_pkg::S_IDLE;
            r_launch    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept;
            if (commit) begin
                r_count <= n_count;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in_data.action;
            r_key    <= i_in_data.value;
        end
        if (r_state == sle_pkg::S_SCAN && i_tok_last.valid) begin
            r_found    <= i_tok_last.eq_seen;
            r_eq_pos   <= i_eq_pos;
            r_stop_pos <= i_stop_pos;
        end
        if (commit) begin
            r_out_data <= n_out_data;
        end
    end

    always_comb begin
        o_tok.valid     = r_launch;
        o_tok.eq_seen   = 1'b0;
        o_tok.stop_seen = 1'b0;
    end

    assign o_key       = r_key;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* bench/tb.sv */
// self-checking bench for sorted_list_engine: list ops against an in-bench list predictor
// depends on rtl/sle_pkg.sv and rtl/sorted_list_engine.sv
module tb;

    localparam int CAPACITY = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    sle_pkg::t_in_item in_data = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_data = 1'b0;
    logic in_ready;
    logic out_valid;
    logic cfg_ready;
    sle_pkg::t_out_item out_data;

    // predictor state: stored values in list order, plus the order bit
    logic signed [sle_pkg::VALUE_W-1:0] list_q[$];
    logic order_desc = 1'b0;
    sle_pkg::t_out_item expected_q[$];

    int errors = 0;
    int burst_left = 0;
    int ready_hold = 0;
    int idle_cycles = 0;

    sorted_list_engine #(.CAPACITY(CAPACITY)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // applies one request to the predicted list and returns its result
    function automatic sle_pkg::t_out_item apply_list_op(sle_pkg::t_in_item req);
        sle_pkg::t_out_item res;
        int hit;
        int pos;
        hit = -1;
        foreach (list_q[k]) begin
            if (hit < 0 && list_q[k] == req.value) hit = k;
        end
        res.found = (hit >= 0);
        res.rank = sle_pkg::RANK_W'((hit >= 0) ? hit : 0);
        res.status = sle_pkg::ST_DONE;
        if (req.action == sle_pkg::ACT_INSERT) begin
            if (list_q.size() >= CAPACITY) begin
                res.status = sle_pkg::ST_FULL;
                res.rank = '0;
            end else begin
                // walk stops at the first entry that does not stay ahead of the new value
                pos = 0;
                while (pos < list_q.size() && (order_desc ? (list_q[pos] >= req.value)
                                                          : (list_q[pos] <= req.value)))
                    pos++;
                list_q.insert(pos, req.value);
                res.rank = sle_pkg::RANK_W'(pos);
            end
        end else if (req.action == sle_pkg::ACT_REMOVE) begin
            if (hit >= 0) list_q.delete(hit);
            else res.status = sle_pkg::ST_MISS;
        end
        res.count = sle_pkg::COUNT_W'(list_q.size());
        return res;
    endfunction

    function automatic logic signed [sle_pkg::VALUE_W-1:0] pick_value();
        logic signed [sle_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $signed($urandom_range(0, 15)) - 8;
            4, 5: v = (list_q.size() > 0) ? list_q[$urandom_range(0, list_q.size() - 1)]
                                           : $signed($urandom());
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 32'sh0000_0000;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $signed($urandom());
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [1:0] act,
                             input logic signed [sle_pkg::VALUE_W-1:0] val);
        sle_pkg::t_in_item req;
        int gap;
        req.action = act;
        req.value = val;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(apply_list_op(req));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);
    endtask

    task automatic write_order(input logic desc);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= desc;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        order_desc = desc;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic test_directed();
        send_item(sle_pkg::ACT_INSERT, 32'sh0000_0000);
        send_item(sle_pkg::ACT_INSERT, 32'sh7fff_ffff);
        send_item(sle_pkg::ACT_INSERT, 32'sh8000_0000);
        send_item(sle_pkg::ACT_INSERT, -32'sd1);
        send_item(sle_pkg::ACT_INSERT, 32'sh0000_0000);   // equal value goes after its twin
        send_item(sle_pkg::ACT_FIND, 32'sh0000_0000);
        send_item(sle_pkg::ACT_FIND, 32'sd5);
        send_item(ACT_UNUSED, 32'sh7fff_ffff);
        send_item(sle_pkg::ACT_REMOVE, 32'sh0000_0000);
        send_item(sle_pkg::ACT_REMOVE, 32'sd12345);
        send_item(sle_pkg::ACT_FIND, 32'sh0000_0000);
        send_item(sle_pkg::ACT_REMOVE, 32'sh8000_0000);
        send_item(sle_pkg::ACT_FIND, 32'sh8000_0000);
        // flip the order with entries still stored
        write_order(1'b1);
        send_item(sle_pkg::ACT_INSERT, 32'sd7);
        send_item(sle_pkg::ACT_INSERT, 32'sh7fff_ffff);
        send_item(sle_pkg::ACT_INSERT, 32'sh8000_0000);
        send_item(sle_pkg::ACT_INSERT, 32'sd7);
        send_item(sle_pkg::ACT_FIND, 32'sd7);
        send_item(sle_pkg::ACT_REMOVE, 32'sh7fff_ffff);
        send_item(sle_pkg::ACT_FIND, -32'sd1);
    endtask

    task automatic test_random_mix(input int n_items);
        int roll;
        int ins_pct;
        repeat (n_items) begin
            ins_pct = (list_q.size() < 8) ? 65 : ((list_q.size() > 56) ? 30 : 45);
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) send_item(sle_pkg::ACT_INSERT, pick_value());
            else if (roll < ins_pct + 30) send_item(sle_pkg::ACT_REMOVE, pick_value());
            else if (roll < 97) send_item(sle_pkg::ACT_FIND, pick_value());
            else send_item(ACT_UNUSED, pick_value());
        end
    endtask

    task automatic test_fill_and_drain();
        while (list_q.size() < CAPACITY) send_item(sle_pkg::ACT_INSERT, pick_value());
        repeat (4) send_item(sle_pkg::ACT_INSERT, pick_value());
        repeat (6) send_item(sle_pkg::ACT_FIND, pick_value());
        while (list_q.size() > 0) begin
            if ($urandom_range(0, 7) == 0) send_item(sle_pkg::ACT_REMOVE, pick_value());
            else send_item(sle_pkg::ACT_REMOVE, list_q[$urandom_range(0, list_q.size() - 1)]);
        end
        send_item(sle_pkg::ACT_REMOVE, pick_value());
        send_item(sle_pkg::ACT_INSERT, pick_value());     // insert into an emptied list
    endtask

    // receiver: long ready runs, short chatter and occasional long stalls
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    out_ready <= 1'b1;
                    ready_hold <= $urandom_range(0, 200);
                end
                4, 5, 6: begin
                    out_ready <= 1'b0;
                    ready_hold <= $urandom_range(0, 3);
                end
                7, 8: begin
                    out_ready <= 1'b1;
                    ready_hold <= $urandom_range(0, 3);
                end
                default: begin
                    out_ready <= 1'b0;
                    ready_hold <= $urandom_range(20, 120);
                end
            endcase
        end
    end

    always @(posedge clk) begin : result_check
        sle_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none got %p", $time, out_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("found", want.found, out_data.found);
                check_field("rank", want.rank, out_data.rank);
                check_field("count", want.count, out_data.count);
                check_field("status", want.status, out_data.status);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix(600);
        write_order(1'b0);
        test_random_mix(400);
        write_order(1'b1);
        test_fill_and_drain();
        write_order(1'b0);
        test_fill_and_drain();
        test_random_mix(400);
        wait_idle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
